/* hw/rtl/spt_pkg.sv */
package spt_pkg;

	// Filter and display configuration
	localparam int FILTER_SHIFT    = 4;
	localparam int DISPLAY_COLUMNS = 60;

	// Sample and result widths
	localparam int SAMPLE_W  = 16;
	localparam int OUT_COL_W = 6;
	localparam int VEL_W     = 32;

	// Gravity estimate holds a sample scaled by 2^FILTER_SHIFT
	localparam int GRAV_W = SAMPLE_W + FILTER_SHIFT;

	// Column arithmetic: av * COL_MAX / peak
	localparam int COL_MAX  = DISPLAY_COLUMNS - 1;
	localparam int COL_W    = $clog2(DISPLAY_COLUMNS);
	localparam int ZERO_COL = (DISPLAY_COLUMNS - 1) / 2;
	localparam int DIVD_W   = VEL_W + COL_W;
	localparam int CNT_W    = $clog2(DIVD_W);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [GRAV_W-1:0]   grav_t;

endpackage

/* hw/rtl/swing_phase_tracker_unit.sv */
// Swing phase tracker.
// Input channel (in_valid/in_ready) takes one three-axis accelerometer beat.
// Output channel (out_valid/out_ready) gives one beat per input: the linear
// acceleration on each axis (sample minus gravity estimate) and the display
// column for the current swing phase.
// The first sample after reset seeds the gravity estimate, so its linear
// values are zero. Velocity integrates the negated linear Y value; a velocity
// sign change ends a swing and sets the peak used to scale the column.
// From an input beat to output valid the sample passes the velocity update,
// the column product and divider start, the serial divider that scales the
// column against the peak one dividend bit per step, a state that sees the
// divider finish, and the load of the output register, which waits while an
// older beat there is still not taken. The divider is the longest step.
// in_ready is high only while no sample is in work. A finished beat waits in
// the output register while the next sample is accepted and processed; if
// the receiver still stalls when that one finishes, the block holds it.
// Reset drops the gravity estimate so the next sample seeds it, clears the
// velocity, sets the peak to 100 and empties the output register.
module swing_phase_tracker_unit import spt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SAMPLE_W-1:0]  accel_x,
	input  logic [SAMPLE_W-1:0]  accel_y,
	input  logic [SAMPLE_W-1:0]  accel_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SAMPLE_W-1:0]  linear_x,
	output logic [SAMPLE_W-1:0]  linear_y,
	output logic [SAMPLE_W-1:0]  linear_z,
	output logic [OUT_COL_W-1:0] column_offset
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_VEL  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd2;

	localparam logic [VEL_W-1:0] PEAK_RESET = VEL_W'(100);
	localparam logic [VEL_W-1:0] VEL_MAX    = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0] VEL_MIN    = {1'b1, {(VEL_W-1){1'b0}}};

	logic [2:0]          state_q;
	logic                seeded_q;
	grav_t               grav_q [3];
	sample_t             lin_q [3];
	logic [VEL_W-1:0]    vel_q;
	logic [VEL_W-1:0]    peak_q;
	logic [VEL_W-1:0]    av_q;
	logic [1:0]          dir_q;
	logic                out_valid_q;
	sample_t             out_lin_q [3];
	logic [OUT_COL_W-1:0] out_col_q;

	logic                in_fire;
	logic                out_free;
	sample_t             samp [3];
	grav_t               grav_nxt [3];
	sample_t             lin_nxt [3];

	logic [VEL_W:0]      vel_sum;
	logic [VEL_W-1:0]    vel_sat;
	logic [1:0]          dir_nxt;
	logic                flip;
	logic [VEL_W-1:0]    vel_mag;

	logic                div_start;
	logic                div_done;
	logic [DIVD_W-1:0]   div_quot;
	logic [DIVD_W-1:0]   col_prod;
	logic [COL_W-1:0]    col_full;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign samp[0] = accel_x;
	assign samp[1] = accel_y;
	assign samp[2] = accel_z;

	// Gravity filter lanes: seed, average, subtract
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			grav_t                  ds;
			grav_t                  g_old;
			logic signed [GRAV_W:0] diff;
			grav_t                  g_sh;
			ds          = $signed({samp[i], {FILTER_SHIFT{1'b0}}});
			g_old       = seeded_q ? grav_q[i] : ds;
			diff        = $signed({ds[GRAV_W-1], ds}) - $signed({g_old[GRAV_W-1], g_old});
			grav_nxt[i] = g_old + GRAV_W'(diff >>> FILTER_SHIFT);
			g_sh        = grav_nxt[i] >>> FILTER_SHIFT;
			lin_nxt[i]  = samp[i] - g_sh[SAMPLE_W-1:0];
		end
	end

	// Velocity step with saturation, then direction and magnitude
	always_comb begin
		vel_sum = {vel_q[VEL_W-1], vel_q}
			- {{(VEL_W + 1 - SAMPLE_W){lin_q[1][SAMPLE_W-1]}}, lin_q[1]};
		if (vel_sum[VEL_W] != vel_sum[VEL_W-1]) begin
			vel_sat = vel_sum[VEL_W] ? VEL_MIN : VEL_MAX;
		end else begin
			vel_sat = vel_sum[VEL_W-1:0];
		end
		dir_nxt = vel_sat[VEL_W-1] ? DIR_NEG : DIR_POS;
		flip    = (dir_q != DIR_NONE) && (dir_nxt != dir_q);
		vel_mag = vel_sat[VEL_W-1] ? (VEL_W'(0) - vel_sat) : vel_sat;
	end

	// Column product feeds the divider
	assign col_prod  = DIVD_W'(av_q) * DIVD_W'(COL_MAX);
	assign div_start = (state_q == ST_MUL);

	spt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (col_prod),
		.divisor  (peak_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Clamp the quotient, or take the center column for a zero peak
	always_comb begin
		if (peak_q == '0) begin
			col_full = COL_W'(ZERO_COL);
		end else if (div_quot > DIVD_W'(COL_MAX)) begin
			col_full = COL_W'(COL_MAX);
		end else begin
			col_full = div_quot[COL_W-1:0];
		end
	end

	// Sequencer and swing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			vel_q       <= '0;
			peak_q      <= PEAK_RESET;
			dir_q       <= DIR_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						seeded_q <= 1'b1;
						state_q  <= ST_VEL;
					end
				end
				ST_VEL: begin
					dir_q <= dir_nxt;
					if (flip) begin
						peak_q <= vel_mag;
						vel_q  <= '0;
					end else begin
						vel_q <= vel_sat;
						if (vel_mag > peak_q) begin
							peak_q <= vel_mag;
						end
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Raise valid on a finished beat, drop it once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold gravity estimate and the sample's linear values
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < 3; i++) begin
				grav_q[i] <= grav_nxt[i];
				lin_q[i]  <= lin_nxt[i];
			end
		end
	end

	// Hold the magnitude that the column is scaled from
	always_ff @(posedge clk) begin
		if (state_q == ST_VEL) begin
			av_q <= flip ? '0 : vel_mag;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			for (int i = 0; i < 3; i++) begin
				out_lin_q[i] <= lin_q[i];
			end
			out_col_q <= OUT_COL_W'(col_full);
		end
	end

	assign out_valid     = out_valid_q;
	assign linear_x      = out_lin_q[0];
	assign linear_y      = out_lin_q[1];
	assign linear_z      = out_lin_q[2];
	assign column_offset = out_col_q;

endmodule

/* hw/rtl/spt_divider.sv */
module spt_divider import spt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [VEL_W-1:0]  divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VEL_W-1:0]  rem_q;
	logic [DIVD_W-1:0] quot_q;

	logic [VEL_W:0]    rem_shift;
	logic              fits;
	logic [VEL_W:0]    rem_diff;

	// One restoring step: bring down the next dividend bit, try to subtract
	assign rem_shift = {rem_q, quot_q[DIVD_W-1]};
	assign fits      = rem_shift >= {1'b0, divisor};
	assign rem_diff  = rem_shift - {1'b0, divisor};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_diff[VEL_W-1:0] : rem_shift[VEL_W-1:0];
			quot_q <= {quot_q[DIVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

/* sim/spt_checker.sv */
`timescale 1ns / 1ps

module swing_tracker_checker import spt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [SAMPLE_W-1:0]  accel_x,
	input  logic [SAMPLE_W-1:0]  accel_y,
	input  logic [SAMPLE_W-1:0]  accel_z,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [SAMPLE_W-1:0]  linear_x,
	input  logic [SAMPLE_W-1:0]  linear_y,
	input  logic [SAMPLE_W-1:0]  linear_z,
	input  logic [OUT_COL_W-1:0] column_offset,
	output int                   mismatches,
	output int                   outstanding,
	output int                   beats_checked,
	output int                   reversals,
	output int                   zero_peak_cols
);

	typedef enum logic [1:0] {DIR_NONE, DIR_POS, DIR_NEG} swing_dir_e;

	typedef struct packed {
		logic [SAMPLE_W-1:0]  lin_x;
		logic [SAMPLE_W-1:0]  lin_y;
		logic [SAMPLE_W-1:0]  lin_z;
		logic [OUT_COL_W-1:0] column;
	} motion_beat_t;

	localparam longint VEL_MAX = 64'sd2147483647;
	localparam longint VEL_MIN = -64'sd2147483648;

	// Predicted tracker state
	longint            gravity [3];
	bit                seeded;
	int                velocity;
	longint unsigned   peak_speed;
	swing_dir_e        swing_dir;
	motion_beat_t      expected_beats [$];

	// Advance the tracker by one sample and return the beat it should produce
	function automatic motion_beat_t predict_motion(input sample_t ax, input sample_t ay,
			input sample_t az);
		sample_t             d [3];
		logic [SAMPLE_W-1:0] lin [3];
		longint              ds;
		longint              g;
		longint              v;
		longint unsigned     av;
		longint unsigned     col;
		swing_dir_e          new_dir;
		int                  i;
		d[0] = ax;
		d[1] = ay;
		d[2] = az;
		// gravity average, floor shifts, linear part wrapped to sample width
		for (i = 0; i < 3; i++) begin
			ds = longint'(d[i]) * (1 << FILTER_SHIFT);
			if (!seeded)
				gravity[i] = ds;
			g = gravity[i] + ((ds - gravity[i]) >>> FILTER_SHIFT);
			gravity[i] = g;
			lin[i] = SAMPLE_W'(longint'(d[i]) - (g >>> FILTER_SHIFT));
		end
		seeded = 1'b1;

		// integrate negated Y, saturate to 32 bits
		v = longint'(velocity) - longint'($signed(lin[1]));
		if (v > VEL_MAX)
			v = VEL_MAX;
		if (v < VEL_MIN)
			v = VEL_MIN;
		velocity = int'(v);

		// a sign change closes the swing: latch its size as the peak
		new_dir = (velocity >= 0) ? DIR_POS : DIR_NEG;
		if (swing_dir != DIR_NONE && new_dir != swing_dir) begin
			peak_speed = (velocity < 0) ? -longint'(velocity) : longint'(velocity);
			velocity = 0;
			reversals++;
		end
		swing_dir = new_dir;

		av = (velocity < 0) ? -longint'(velocity) : longint'(velocity);
		if (av > peak_speed)
			peak_speed = av;

		// scale phase to a display column
		if (peak_speed == 0) begin
			col = ZERO_COL;
			zero_peak_cols++;
		end else begin
			col = av * COL_MAX / peak_speed;
			if (col > COL_MAX)
				col = COL_MAX;
		end
		predict_motion = '{lin[0], lin[1], lin[2], col[OUT_COL_W-1:0]};
	endfunction

	task automatic compare_field(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Match each output beat against the oldest prediction, then queue new ones
	always @(posedge clk or negedge arst_n) begin : track
		motion_beat_t want;
		if (!arst_n) begin
			gravity[0] = 0;
			gravity[1] = 0;
			gravity[2] = 0;
			seeded = 1'b0;
			velocity = 0;
			peak_speed = 100;
			swing_dir = DIR_NONE;
			expected_beats.delete();
			mismatches = 0;
			outstanding = 0;
			beats_checked = 0;
			reversals = 0;
			zero_peak_cols = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$error("output beat with no sample outstanding");
					mismatches++;
				end else begin
					want = expected_beats.pop_front();
					beats_checked++;
					compare_field("linear_x", $signed(want.lin_x), $signed(linear_x));
					compare_field("linear_y", $signed(want.lin_y), $signed(linear_y));
					compare_field("linear_z", $signed(want.lin_z), $signed(linear_z));
					compare_field("column_offset", want.column, column_offset);
				end
			end
			if (in_valid && in_ready)
				expected_beats.push_back(predict_motion(accel_x, accel_y, accel_z));
			outstanding = expected_beats.size();
		end
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import spt_pkg::*;

	localparam int SAMPLE_COUNT = 1200;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 60;

	typedef enum {SEG_SWING, SEG_NOISE, SEG_STILL} segment_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	sample_t              accel_x = '0;
	sample_t              accel_y = '0;
	sample_t              accel_z = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [SAMPLE_W-1:0]  linear_x;
	logic [SAMPLE_W-1:0]  linear_y;
	logic [SAMPLE_W-1:0]  linear_z;
	logic [OUT_COL_W-1:0] column_offset;

	int mismatches;
	int outstanding;
	int beats_checked;
	int reversals;
	int zero_peak_cols;
	int samples_sent = 0;
	int idle_cycles = 0;
	bit send_calm = 1'b0;

	always #5 clk = ~clk;

	swing_phase_tracker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.accel_x       (accel_x),
		.accel_y       (accel_y),
		.accel_z       (accel_z),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.linear_x      (linear_x),
		.linear_y      (linear_y),
		.linear_z      (linear_z),
		.column_offset (column_offset)
	);

	swing_tracker_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.linear_x       (linear_x),
		.linear_y       (linear_y),
		.linear_z       (linear_z),
		.column_offset  (column_offset),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.beats_checked  (beats_checked),
		.reversals      (reversals),
		.zero_peak_cols (zero_peak_cols)
	);

	function automatic sample_t clip16(input int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return sample_t'(v);
	endfunction

	// Present one sample beat after a random gap and hold it until accepted
	task automatic send_sample(input sample_t sx, input sample_t sy, input sample_t sz);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= sx;
		accel_y <= sy;
		accel_z <= sz;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
	endtask

	// Stall the output side per beat, with calm stretches holding ready high
	initial begin : drain
		int stall;
		int calm_left;
		calm_left = 0;
		@(posedge arst_n);
		forever begin
			if (calm_left > 0) begin
				stall = 0;
				calm_left--;
			end else if ($urandom_range(0, 7) == 0) begin
				calm_left = $urandom_range(10, 40);
				stall = 0;
			end else begin
				stall = $urandom_range(0, 5);
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				do @(posedge clk); while (!out_valid);
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		segment_e mode;
		int       seg_len;
		int       k;
		int       r;
		int       base_x;
		int       base_y;
		int       base_z;
		int       amp;
		int       period;
		int       phase;
		int       p;
		int       t;
		sample_t  sx;
		sample_t  sy;
		sample_t  sz;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// seed from the range extremes, then wrap the linear part both ways
		send_sample(16'sh8000, 16'sd0, 16'sh7fff);
		send_sample(16'sh7fff, 16'sd16, 16'sh8000);
		// the Y step above reverses the swing; this lands velocity on zero
		send_sample(16'sd0, 16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd1, 16'sd0);
		// full-scale swings in both directions
		send_sample(-16'sd1, 16'sh7fff, 16'sd1);
		send_sample(-16'sd1, 16'sh8000, 16'sd1);
		send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(16'sh5555, 16'sh5555, 16'sh5555);
		send_sample(16'shaaaa, 16'shaaaa, 16'shaaaa);
		send_sample(16'sd1, -16'sd1, 16'sd1);
		send_sample(-16'sd1, 16'sd1, -16'sd1);
		// steady pull lets velocity grow and the column ramp
		repeat (5) send_sample(16'sd100, -16'sd20000, -16'sd100);
		repeat (3) send_sample(16'sd100, 16'sd20000, -16'sd100);

		// random segments: mostly swing-like motion, some noise and still periods
		while (samples_sent < SAMPLE_COUNT) begin
			r = $urandom_range(0, 9);
			mode = (r < 6) ? SEG_SWING : (r < 8) ? SEG_NOISE : SEG_STILL;
			seg_len = $urandom_range(20, 80);
			send_calm = ($urandom_range(0, 3) == 0);
			base_x = int'($urandom_range(0, 16000)) - 8000;
			base_y = int'($urandom_range(0, 16000)) - 8000;
			base_z = int'($urandom_range(0, 16000)) - 8000;
			amp = $urandom_range(0, 20000);
			period = $urandom_range(8, 40);
			phase = $urandom_range(0, period - 1);
			for (k = 0; k < seg_len && samples_sent < SAMPLE_COUNT; k++) begin
				case (mode)
					SEG_SWING: begin
						p = (phase + k) % period;
						t = (p < period / 2) ? p : period - p;
						sx = clip16(base_x + int'($urandom_range(0, 63)) - 32);
						sy = clip16(base_y + amp * (4 * t - period) / period
							+ int'($urandom_range(0, 63)) - 32);
						sz = clip16(base_z + int'($urandom_range(0, 63)) - 32);
					end
					SEG_NOISE: begin
						sx = sample_t'($urandom);
						sy = sample_t'($urandom);
						sz = sample_t'($urandom);
					end
					default: begin
						sx = clip16(base_x);
						sy = clip16(base_y + int'($urandom_range(0, 2)) - 1);
						sz = clip16(base_z);
					end
				endcase
				send_sample(sx, sy, sz);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then give the block time to show any stray beat
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d samples sent, %0d result beats checked, %0d mismatches",
			samples_sent, beats_checked, mismatches);
		$display("run: %0d swing reversals, %0d columns from a zero peak",
			reversals, zero_peak_cols);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/spt_pkg.sv
hw/rtl/spt_divider.sv
hw/rtl/swing_phase_tracker_unit.sv
sim/spt_checker.sv
sim/testbench.sv
